// ===== hw/rtl/lvp_pkg.sv =====
// Shared types, widths, register codes and sine table builder for the line projector.
package lvp_pkg;

  // Pixel coordinate width and bounds
  localparam int PW = 13;
  localparam logic signed [PW-1:0] PIX_MAX = 13'sd4095;
  localparam logic signed [PW-1:0] PIX_MIN = -13'sd4096;

  // Camera-space coordinate widths
  localparam int XCW = 19;
  localparam int ZW  = XCW - 1;
  localparam int XFW = XCW + 17;
  localparam int YFW = 33;
  localparam int MW  = 51;
  localparam int KW  = 27;

  // Divider geometry: one quotient bit per stage
  localparam int DIV_STAGES = PW;
  localparam int RW         = ZW + 2 * DIV_STAGES;
  localparam int DIV_LAT    = DIV_STAGES + 1;
  localparam int BACK_LAT   = DIV_LAT + 2;

  // Queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 32;

  // Quarter turn in unsigned Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_VIEW_ANGLE = 2'd0,
    REG_CAM_X      = 2'd1,
    REG_CAM_Z      = 2'd2,
    REG_FOCAL      = 2'd3
  } cfg_reg_t;

  // One vertex after rotation and offset
  typedef struct packed {
    logic signed [XCW-1:0] xc;
    logic signed [XCW-1:0] zc;
    logic signed [15:0]    y;
  } vtx_t;

  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
  } mid_t;

  // One result word
  typedef struct packed {
    logic signed [PW-1:0] start_screen_x;
    logic signed [PW-1:0] start_screen_y;
    logic signed [PW-1:0] end_screen_x;
    logic signed [PW-1:0] end_screen_y;
    logic                 behind_camera;
  } res_t;

  // Sine of a Q2.30 angle: 9-term Taylor series, rounded to Q1.12 and capped at one
  function automatic logic [12:0] sine_entry(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    sum  = x;
    term = x;
    for (int k = 1; k <= 8; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / TAYLOR_DIV[k-1];
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    e = (sum + (64'd1 << 17)) >> 18;
    if (e > 64'd4096) begin
      e = 64'd4096;
    end
    return 13'(e);
  endfunction

endpackage

// ===== hw/rtl/lvp_fifo.sv =====
// Small first-in first-out queue with combinational head read.
module lvp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // Advance pointers with wrap at the depth
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  assign rdata = mem[rptr_r];
  assign empty = (cnt_r == '0);

endmodule

// ===== hw/rtl/lvp_front.sv =====
// Front end: takes line words, rotates both vertices and adds the camera offsets.
module lvp_front import lvp_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_start_z,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_end_z,
  input  logic [15:0]        view_angle,
  input  logic signed [15:0] cam_x,
  input  logic signed [15:0] cam_z,
  output logic               mid_push,
  output mid_t               mid_data,
  input  logic               mid_pop
);

  localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PRW = 14 + IW;
  localparam int CW  = $clog2(MID_DEPTH + 1);

  // Quarter-wave sine table
  logic [12:0] sine_tab [SINE_TABLE_DEPTH + 1];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_tab
    localparam logic [63:0] XQ = (64'(i) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign sine_tab[i] = sine_entry(XQ);
  end

  // Fold an angle onto the quarter wave: sign bit and table index
  function automatic logic [IW:0] tab_sel(input logic [15:0] a);
    logic [PRW-1:0] prod;
    logic [IW-1:0]  idx;
    prod = PRW'(a[13:0]) * PRW'(SINE_TABLE_DEPTH);
    idx  = IW'(prod >> 14);
    if (a[14]) begin
      idx = IW'(SINE_TABLE_DEPTH) - idx;
    end
    return {a[15], idx};
  endfunction

  logic [IW:0]        sel_s, sel_c;
  logic [13:0]        mag_s, mag_c;
  logic signed [13:0] sin_r, cos_r;

  assign sel_s = tab_sel(view_angle);
  assign sel_c = tab_sel(view_angle + 16'd16384);
  assign mag_s = {1'b0, sine_tab[sel_s[IW-1:0]]};
  assign mag_c = {1'b0, sine_tab[sel_c[IW-1:0]]};

  // Hold sine and cosine of the current view angle
  always_ff @(posedge clk) begin
    sin_r <= sel_s[IW] ? -$signed(mag_s) : $signed(mag_s);
    cos_r <= sel_c[IW] ? -$signed(mag_c) : $signed(mag_c);
  end

  // Credit count: words in flight here plus words waiting in the queue
  logic          acc;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full = (cnt_r == CW'(MID_DEPTH));
  assign acc  = push && !full;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !mid_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (mid_pop && !acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Stage valids
  logic v1_r, v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v1_r  <= acc;
      v2_r  <= v1_r;
    end
  end

  // Register the accepted word
  logic signed [15:0] x_r [2];
  logic signed [15:0] y_r [2];
  logic signed [15:0] z_r [2];

  always_ff @(posedge clk) begin
    if (acc) begin
      x_r[0] <= in_start_x;
      y_r[0] <= in_start_y;
      z_r[0] <= in_start_z;
      x_r[1] <= in_end_x;
      y_r[1] <= in_end_y;
      z_r[1] <= in_end_z;
    end
  end

  // Rotation products, then sum, round and offset
  logic signed [29:0] pxc_r [2];
  logic signed [29:0] pzs_r [2];
  logic signed [29:0] pxs_r [2];
  logic signed [29:0] pzc_r [2];
  logic signed [15:0] y2_r  [2];
  vtx_t               vtx   [2];

  for (genvar v = 0; v < 2; v++) begin : g_vtx
    logic signed [31:0] xsum, zsum, xrot, zrot;

    always_ff @(posedge clk) begin
      pxc_r[v] <= x_r[v] * cos_r;
      pzs_r[v] <= z_r[v] * sin_r;
      pxs_r[v] <= x_r[v] * sin_r;
      pzc_r[v] <= z_r[v] * cos_r;
      y2_r[v]  <= y_r[v];
    end

    always_comb begin
      xsum       = 32'(pxc_r[v]) - 32'(pzs_r[v]) + 32'sd2048;
      zsum       = 32'(pxs_r[v]) + 32'(pzc_r[v]) + 32'sd2048;
      xrot       = xsum >>> 12;
      zrot       = zsum >>> 12;
      vtx[v].xc  = XCW'(xrot + 32'(cam_x));
      vtx[v].zc  = XCW'(zrot + 32'(cam_z));
      vtx[v].y   = y2_r[v];
    end
  end

  assign mid_push    = v2_r;
  assign mid_data.v0 = vtx[0];
  assign mid_data.v1 = vtx[1];

endmodule

// ===== hw/rtl/lvp_div.sv =====
// Pipelined restoring divider giving one clamped pixel coordinate.
module lvp_div import lvp_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] m,
  input  logic [ZW-1:0]        zc,
  output logic signed [PW-1:0] q
);

  logic [RW-1:0]   r_r   [DIV_STAGES + 1];
  logic [ZW-1:0]   z_r   [DIV_STAGES + 1];
  logic [PW-1:0]   q_r   [DIV_STAGES + 1];
  logic [DIV_STAGES:0] neg_r, ovf_r;
  logic [MW-1:0]   lim0;

  // Range check: below the low bound or at or above the high bound
  assign lim0 = MW'(zc) << (2 * DIV_STAGES);

  always_ff @(posedge clk) begin
    neg_r[0] <= m[MW-1];
    ovf_r[0] <= !m[MW-1] && ($unsigned(m) >= lim0);
    r_r[0]   <= m[RW-1:0];
    z_r[0]   <= zc;
    q_r[0]   <= '0;
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int SH = 2 * DIV_STAGES - 1 - j;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(z_r[j]) << SH;
    assign ge    = (r_r[j] >= trial);

    always_ff @(posedge clk) begin
      r_r[j+1]   <= ge ? r_r[j] - trial : r_r[j];
      q_r[j+1]   <= {q_r[j][PW-2:0], ge};
      z_r[j+1]   <= z_r[j];
      neg_r[j+1] <= neg_r[j];
      ovf_r[j+1] <= ovf_r[j];
    end
  end

  // Remove the bias of 4096 by flipping the top bit
  always_comb begin
    if (neg_r[DIV_STAGES]) begin
      q = PIX_MIN;
    end else if (ovf_r[DIV_STAGES]) begin
      q = PIX_MAX;
    end else begin
      q = $signed({~q_r[DIV_STAGES][PW-1], q_r[DIV_STAGES][PW-2:0]});
    end
  end

endmodule

// ===== hw/rtl/lvp_vertex.sv =====
// Projection of one vertex to screen pixels, fixed latency, no stall.
module lvp_vertex import lvp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 800
) (
  input  logic                 clk,
  input  vtx_t                 vin,
  input  logic [15:0]          focal,
  output logic signed [PW-1:0] sx,
  output logic signed [PW-1:0] sy,
  output logic                 behind
);

  localparam logic signed [13:0]   W_S  = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0]   H_S  = 14'(SCREEN_HEIGHT);
  localparam logic signed [KW-1:0] KX_S = KW'(4096 * (SCREEN_WIDTH + 8193));
  localparam logic signed [KW-1:0] KY_S = KW'(4096 * (SCREEN_HEIGHT + 8193));
  localparam logic signed [PW-1:0] HALF_W = PW'(SCREEN_WIDTH / 2);
  localparam logic signed [PW-1:0] HALF_H = PW'(SCREEN_HEIGHT / 2);

  // Scale by the focal length
  logic signed [XFW-1:0] xf_r;
  logic signed [YFW-1:0] yf_r;
  logic signed [XCW-1:0] zc1_r;

  always_ff @(posedge clk) begin
    xf_r  <= vin.xc * $signed({1'b0, focal});
    yf_r  <= vin.y * $signed({1'b0, focal});
    zc1_r <= vin.zc;
  end

  // Scale by screen size and build the biased numerator terms
  logic signed [MW-1:0]  wxf_r, hyf_r, zkx_r, zky_r;
  logic [ZW-1:0]         zc2_r;
  logic                  beh2_r, xpos2_r, xneg2_r, ypos2_r, yneg2_r;

  always_ff @(posedge clk) begin
    wxf_r   <= xf_r * W_S;
    hyf_r   <= yf_r * H_S;
    zkx_r   <= zc1_r * KX_S;
    zky_r   <= zc1_r * KY_S;
    zc2_r   <= zc1_r[ZW-1:0];
    beh2_r  <= (zc1_r <= 0);
    xpos2_r <= (xf_r > 0);
    xneg2_r <= (xf_r < 0);
    ypos2_r <= (yf_r > 0);
    yneg2_r <= (yf_r < 0);
  end

  logic signed [MW-1:0] mx, my;
  logic signed [PW-1:0] qx, qy;

  assign mx = wxf_r + zkx_r;
  assign my = zky_r - hyf_r;

  lvp_div u_div_x (.clk(clk), .m(mx), .zc(zc2_r), .q(qx));
  lvp_div u_div_y (.clk(clk), .m(my), .zc(zc2_r), .q(qy));

  // Delay the depth and sign flags alongside the dividers
  logic [4:0] flg_r [DIV_LAT];

  always_ff @(posedge clk) begin
    flg_r[0] <= {beh2_r, xpos2_r, xneg2_r, ypos2_r, yneg2_r};
    for (int i = 1; i < DIV_LAT; i++) begin
      flg_r[i] <= flg_r[i-1];
    end
  end

  // Select divided result or the behind-camera edge values
  logic beh, xpos, xneg, ypos, yneg;

  assign {beh, xpos, xneg, ypos, yneg} = flg_r[DIV_LAT-1];

  always_comb begin
    if (beh) begin
      sx = xpos ? PIX_MAX : (xneg ? PIX_MIN : HALF_W);
      sy = ypos ? PIX_MIN : (yneg ? PIX_MAX : HALF_H);
    end else begin
      sx = qx;
      sy = qy;
    end
  end

  assign behind = beh;

endmodule

// ===== hw/rtl/lvp_back.sv =====
// Back end: projects queued vertex pairs and buffers the result words.
module lvp_back import lvp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 800
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  mid_t                 mid_data,
  output logic                 mid_pop,
  input  logic [15:0]          focal,
  output logic                 empty,
  input  logic                 pop,
  output res_t                 res
);

  localparam int CW = $clog2(OUT_DEPTH + 1);

  // Credit count: words in the pipeline plus words in the output queue
  logic          out_pop;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [BACK_LAT-1:0] vld_r;

  assign out_pop = pop && !empty;
  assign mid_pop = !mid_empty && (cnt_r != CW'(OUT_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (mid_pop && !out_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_pop && !mid_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Advance the valid line with the payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      vld_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      vld_r <= {vld_r[BACK_LAT-2:0], mid_pop};
    end
  end

  logic                 beh0, beh1;
  logic signed [PW-1:0] sx0, sy0, sx1, sy1;
  res_t                 res_w;

  lvp_vertex #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_vtx0 (
    .clk(clk), .vin(mid_data.v0), .focal(focal),
    .sx(sx0), .sy(sy0), .behind(beh0)
  );

  lvp_vertex #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_vtx1 (
    .clk(clk), .vin(mid_data.v1), .focal(focal),
    .sx(sx1), .sy(sy1), .behind(beh1)
  );

  assign res_w = {sx0, sy0, sx1, sy1, beh0 | beh1};

  // Buffer finished words for the consumer
  logic [$bits(res_t)-1:0] rdata;

  lvp_fifo #(.WIDTH($bits(res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(vld_r[BACK_LAT-1]), .wdata(res_w),
    .pop(out_pop), .rdata(rdata), .empty(empty)
  );

  assign res = res_t'(rdata);

endmodule

// ===== hw/rtl/line_vertex_project_core.sv =====
// Top level: perspective projection of one line segment per word.
//
// Input side is a queue: present a line on the in_ ports with push; the word
// is taken at a clock edge where push is high and full is low. Result side is
// a queue too: while empty is low the oldest result stands on the out_ ports
// and is taken at an edge where pop is high.
// One line is accepted per cycle while full is low. From acceptance a word
// passes the input and product registers of the rotation in the front end,
// the middle queue, the focal and screen scaling registers, a range check
// stage and a 13-stage divider with one quotient bit per stage, and the
// output queue. A 4-word queue separates the front end from the projection
// pipeline, and a 32-word output queue holds results; when the receiver
// stops popping the pipeline drains into the output queue and full rises
// once both fill. Configuration writes land in the cycle after cfg_we; the
// view angle then passes the sine and cosine registers to the rotation.
// Reset (rst_n low at a clock edge) empties both queues and the pipeline
// and loads view angle 0, offsets x 0 and z 3.0, focal length 1.5.
module line_vertex_project_core import lvp_pkg::*; #(
  parameter int SCREEN_WIDTH     = 800,
  parameter int SCREEN_HEIGHT    = 800,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   in_start_x,
  input  logic signed [15:0]   in_start_y,
  input  logic signed [15:0]   in_start_z,
  input  logic signed [15:0]   in_end_x,
  input  logic signed [15:0]   in_end_y,
  input  logic signed [15:0]   in_end_z,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [PW-1:0] out_start_screen_x,
  output logic signed [PW-1:0] out_start_screen_y,
  output logic signed [PW-1:0] out_end_screen_x,
  output logic signed [PW-1:0] out_end_screen_y,
  output logic                 out_behind_camera,
  input  logic                 cfg_we,
  input  cfg_reg_t             cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers
  logic [15:0]        angle_r;
  logic signed [15:0] cam_x_r, cam_z_r;
  logic [15:0]        focal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= 16'd0;
      cam_x_r <= 16'sd0;
      cam_z_r <= 16'sd12288;
      focal_r <= 16'd6144;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_ANGLE: angle_r <= cfg_data;
        REG_CAM_X:      cam_x_r <= $signed(cfg_data);
        REG_CAM_Z:      cam_z_r <= $signed(cfg_data);
        REG_FOCAL:      focal_r <= cfg_data;
      endcase
    end
  end

  logic mid_push, mid_pop, mid_empty;
  mid_t mid_wdata;
  logic [$bits(mid_t)-1:0] mid_rdata;
  res_t res;

  lvp_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_start_x(in_start_x), .in_start_y(in_start_y), .in_start_z(in_start_z),
    .in_end_x(in_end_x), .in_end_y(in_end_y), .in_end_z(in_end_z),
    .view_angle(angle_r), .cam_x(cam_x_r), .cam_z(cam_z_r),
    .mid_push(mid_push), .mid_data(mid_wdata), .mid_pop(mid_pop)
  );

  // Decouple the front end from the projection pipeline
  lvp_fifo #(.WIDTH($bits(mid_t)), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n),
    .push(mid_push), .wdata(mid_wdata),
    .pop(mid_pop), .rdata(mid_rdata), .empty(mid_empty)
  );

  lvp_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk(clk), .rst_n(rst_n),
    .mid_empty(mid_empty), .mid_data(mid_t'(mid_rdata)), .mid_pop(mid_pop),
    .focal(focal_r), .empty(empty), .pop(pop), .res(res)
  );

  assign out_start_screen_x = res.start_screen_x;
  assign out_start_screen_y = res.start_screen_y;
  assign out_end_screen_x   = res.end_screen_x;
  assign out_end_screen_y   = res.end_screen_y;
  assign out_behind_camera  = res.behind_camera;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the line projection core: predicts each result word and checks it.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lvp_pkg::*;

  localparam int SW = 800;
  localparam int SH = 800;
  localparam int TAB_DEPTH = 256;
  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  logic signed [15:0] in_start_x, in_start_y, in_start_z, in_end_x, in_end_y, in_end_z;
  logic empty;
  logic pop;
  logic signed [PW-1:0] out_start_screen_x, out_start_screen_y;
  logic signed [PW-1:0] out_end_screen_x, out_end_screen_y;
  logic out_behind_camera;
  logic cfg_we;
  cfg_reg_t cfg_index;
  logic [15:0] cfg_data;

  line_vertex_project_core #(
    .SCREEN_WIDTH(SW), .SCREEN_HEIGHT(SH), .SINE_TABLE_DEPTH(TAB_DEPTH)
  ) i_dut (.*);

  // Bench copy of the registers and the quarter-wave table
  logic [15:0] angle_q;
  longint cam_x, cam_z, focal;
  longint sine_q12 [TAB_DEPTH+1];
  res_t expected_words[$];
  int fail_count = 0;
  longint cycles = 0;
  bit pop_calm = 0;
  bit push_calm = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Guard against a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint floor_div(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic longint clamp_pixel(longint v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  // Build the table from a Taylor series in Q2.30
  task automatic build_sine_table();
    longint unsigned x, sum, term, e;
    for (int i = 0; i <= TAB_DEPTH; i++) begin
      x = (longint'(i) * 64'd1686629713) / TAB_DEPTH;
      sum = x;
      term = x;
      for (int k = 1; k <= 8; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      e = (sum + (64'd1 << 17)) >> 18;
      if (e > 4096) e = 4096;
      sine_q12[i] = e;
    end
  endtask

  function automatic longint sine_of(logic [15:0] a);
    int idx;
    longint v;
    idx = (int'(a[13:0]) * TAB_DEPTH) >> 14;
    v = a[14] ? sine_q12[TAB_DEPTH - idx] : sine_q12[idx];
    return a[15] ? -v : v;
  endfunction

  // Rotate, offset and project one vertex; returns the behind-camera flag
  function automatic bit project_vertex(longint x, longint y, longint z,
                                        output longint sx, output longint sy);
    longint s, c, xc, zc, xf, yf, den;
    s = sine_of(angle_q);
    c = sine_of(angle_q + 16'd16384);
    xc = floor_div(x * c - z * s + 2048, 4096) + cam_x;
    zc = floor_div(x * s + z * c + 2048, 4096) + cam_z;
    xf = xc * focal;
    yf = y * focal;
    if (zc <= 0) begin
      sx = (xf > 0) ? 4095 : ((xf < 0) ? -4096 : SW / 2);
      sy = (yf > 0) ? -4096 : ((yf < 0) ? 4095 : SH / 2);
      return 1;
    end
    den = 8192 * zc;
    sx = clamp_pixel(floor_div(SW * (4096 * zc + xf) + 4096 * zc, den));
    sy = clamp_pixel(floor_div(SH * (4096 * zc - yf) + 4096 * zc, den));
    return 0;
  endfunction

  function automatic res_t project_line(logic signed [15:0] sx0, sy0, sz0, ex0, ey0, ez0);
    res_t r;
    longint ax, ay, bx, by;
    bit b;
    b = project_vertex(sx0, sy0, sz0, ax, ay);
    b |= project_vertex(ex0, ey0, ez0, bx, by);
    r.start_screen_x = PW'(ax);
    r.start_screen_y = PW'(ay);
    r.end_screen_x = PW'(bx);
    r.end_screen_y = PW'(by);
    r.behind_camera = b;
    return r;
  endfunction

  // Send one line word, predicting its result when taken; push stays high
  // so that the next word can follow without a gap
  task automatic send_line(logic signed [15:0] sx0, sy0, sz0, ex0, ey0, ez0);
    while (!push_calm && $urandom_range(99) < 16) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    in_start_x <= sx0; in_start_y <= sy0; in_start_z <= sz0;
    in_end_x <= ex0; in_end_y <= ey0; in_end_z <= ez0;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_words.push_back(project_line(sx0, sy0, sz0, ex0, ey0, ez0));
    @(negedge clk);
  endtask

  // Write one register, keeping the bench copy in step
  task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      REG_VIEW_ANGLE: angle_q = val;
      REG_CAM_X: cam_x = longint'($signed(val));
      REG_CAM_Z: cam_z = longint'($signed(val));
      REG_FOCAL: focal = longint'(val);
      default: ;
    endcase
  endtask

  // Wait until every expected word has come back and the pipe is quiet
  task automatic drain();
    push <= 0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic set_camera(logic [15:0] a, logic [15:0] ox, logic [15:0] oz, logic [15:0] f);
    drain();
    write_reg(REG_VIEW_ANGLE, a);
    write_reg(REG_CAM_X, ox);
    write_reg(REG_CAM_Z, oz);
    write_reg(REG_FOCAL, f);
    cfg_we <= 0;
    repeat (3) @(negedge clk);
  endtask

  task automatic random_line(int near_pct);
    logic signed [15:0] v [6];
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(99) < near_pct) v[i] = 16'($signed($urandom_range(16383)) - 8192);
      else v[i] = 16'($urandom);
    end
    send_line(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  // Field extremes, zero depth, behind camera and overflow at reset settings
  task automatic test_directed_lines();
    send_line(0, 0, 0, 0, 0, 0);
    send_line(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000);
    send_line(-16'sh8000, 16'sh7fff, 0, 16'sh7fff, -16'sh8000, 0);
    send_line(0, 0, -16'sd12288, 4096, 4096, -16'sd12288);
    send_line(4096, -4096, -16'sd20000, 0, 0, -16'sd13000);
    send_line(16'sh7fff, 0, -16'sd12000, -16'sh8000, 0, -16'sd12287);
    send_line(1, -1, 1, -1, 1, -1);
    send_line(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    send_line(-16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555, -16'sh5556, 16'sh5555);
  endtask

  // Sweep quadrants and extremes of every register
  task automatic test_register_extremes();
    logic [15:0] angles [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2345};
    foreach (angles[i]) begin
      set_camera(angles[i], 16'h0000, 16'd12288, 16'd6144);
      send_line(4096, 4096, 4096, -4096, -4096, 8192);
      send_line(16'sh7fff, 0, 16'sh7fff, 0, 0, -16'sh8000);
    end
    set_camera(16'h1000, 16'h7fff, 16'h7fff, 16'hffff);
    send_line(0, 16'sh7fff, 0, 0, -16'sh8000, 0);
    set_camera(16'hf000, 16'h8000, 16'h8000, 16'h0000);
    send_line(0, 16'sh7fff, 0, 100, -16'sh8000, 0);
    set_camera(16'h0000, 16'h0000, 16'h0001, 16'h0001);
    send_line(0, 16'sh7fff, 0, 16'sh7fff, -16'sh8000, 16'sh7fff);
  endtask

  // Random lines over several camera settings, mostly in front of the camera
  task automatic test_random_lines();
    for (int phase = 0; phase < 7; phase++) begin
      set_camera(16'($urandom), 16'($signed($urandom_range(8191)) - 4096),
                 (phase == 6) ? 16'($urandom) : 16'($urandom_range(40000, 8192)),
                 16'($urandom_range(16384)));
      push_calm = (phase == 3);
      pop_calm = (phase == 3);
      for (int n = 0; n < 200; n++) random_line(75);
    end
    push_calm = 0;
    pop_calm = 0;
  endtask

  // Pop side: random stalls, checked against the oldest prediction
  always @(negedge clk) begin
    pop <= pop_calm ? 1'b1 : ($urandom_range(99) >= 16);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_start_screen_x !== want.start_screen_x) begin
          $error("start_screen_x exp %0d got %0d", want.start_screen_x, out_start_screen_x);
          fail_count++;
        end
        if (out_start_screen_y !== want.start_screen_y) begin
          $error("start_screen_y exp %0d got %0d", want.start_screen_y, out_start_screen_y);
          fail_count++;
        end
        if (out_end_screen_x !== want.end_screen_x) begin
          $error("end_screen_x exp %0d got %0d", want.end_screen_x, out_end_screen_x);
          fail_count++;
        end
        if (out_end_screen_y !== want.end_screen_y) begin
          $error("end_screen_y exp %0d got %0d", want.end_screen_y, out_end_screen_y);
          fail_count++;
        end
        if (out_behind_camera !== want.behind_camera) begin
          $error("behind_camera exp %0d got %0d", want.behind_camera, out_behind_camera);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n = 0;
    push = 0;
    cfg_we = 0;
    cfg_index = REG_VIEW_ANGLE;
    cfg_data = 0;
    in_start_x = 0; in_start_y = 0; in_start_z = 0;
    in_end_x = 0; in_end_y = 0; in_end_z = 0;
    angle_q = 0;
    cam_x = 0;
    cam_z = 12288;
    focal = 6144;
    build_sine_table();
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    test_directed_lines();
    test_register_extremes();
    test_random_lines();
    drain();
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
